FILE: hdl/lkvc_pkg.sv
// Package for the LRU key-value cache: payload structs, cell types and constants.
// No dependencies. Used by lkvc_cell and lru_key_value_cache_core.
`default_nettype none

package lkvc_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e    operation;
    key_t   key;
    value_t write_value;
  } req_t;

  typedef struct packed {
    logic   hit;
    value_t read_value;
  } rsp_t;

  // per-cell command, broadcast along the chain
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_MATCH  = 3'd1,
    CELL_UPDATE = 3'd2,
    CELL_INSERT = 3'd3,
    CELL_MOVE   = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    key_t     key;
    value_t   value;
  } cell_ctrl_t;

  typedef struct packed {
    logic   valid;
    logic   mark;
    key_t   key;
    value_t value;
  } cell_t;

endpackage

`default_nettype wire

FILE: hdl/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: control sequencer and the cell chain.
// Depends on lkvc_pkg and lkvc_cell.
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Entries sit in a chain of cells ordered by recency, most recent in cell 0,
// and valid entries always fill cells 0 to count-1. A request is compared
// against all cells at once, then the hit or newly written entry is swapped
// toward cell 0 one cell per cycle. An accepted request passes the match,
// scan and move states (a get miss skips the move); a get then loads the
// result register in a response state, waiting there while the output stalls.
// No new request is taken before idle again, and the swap walk sets when that is.
// A new key lands at position count, or over the oldest entry when the
// capacity is reached. A get returns hit and the value, or hit clear and -1.
// Capacity 0 acts as 1, capacity above ENTRIES acts as ENTRIES. There is no
// clearing pass after reset.

module lru_key_value_cache_core #(
  parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  lkvc_pkg::req_t              in_req_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output lkvc_pkg::rsp_t              out_rsp_o,
  input  wire                         cfg_we_i,
  input  wire  [lkvc_pkg::CAP_W-1:0]  cfg_wdata_i
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EXT_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MATCH = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_MOVE  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  lkvc_pkg::req_t             req_q;
  logic                       hit_q, hit_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [lkvc_pkg::CAP_W-1:0] capacity_q;
  logic                       out_valid_q, out_valid_d;
  lkvc_pkg::rsp_t             out_rsp_q;
  logic                       rsp_load;

  lkvc_pkg::cell_ctrl_t       ctrl;
  lkvc_pkg::cell_t            chain [ENTRIES];
  logic [ENTRIES-1:0]         mark_vec;
  logic [ENTRIES-1:0]         valid_vec;
  logic                       any_mark;

  logic [EXT_W-1:0]           cap_ext;
  logic [EXT_W-1:0]           cap_eff;
  logic                       full;
  logic [CNT_W-1:0]           slot;

  logic                       in_fire;
  logic                       out_fire;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  assign any_mark = |mark_vec;

  always_comb begin
    cap_ext = EXT_W'(capacity_q);
    if (cap_ext == '0) begin
      cap_eff = EXT_W'(1);
    end else if (cap_ext > EXT_W'(ENTRIES)) begin
      cap_eff = EXT_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full = EXT_W'(count_q) >= cap_eff;
  assign slot = full ? (count_q - CNT_W'(1)) : count_q;

  always_comb begin
    state_d  = state_q;
    hit_d    = hit_q;
    count_d  = count_q;
    rsp_load = 1'b0;
    ctrl     = '{op: lkvc_pkg::CELL_HOLD, key: req_q.key, value: req_q.write_value};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        ctrl.op = lkvc_pkg::CELL_MATCH;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        hit_d = any_mark;
        if (req_q.operation == lkvc_pkg::OP_PUT) begin
          state_d = ST_MOVE;
          if (any_mark) begin
            ctrl.op = lkvc_pkg::CELL_UPDATE;
          end else begin
            ctrl.op = lkvc_pkg::CELL_INSERT;
            if (!full) begin
              count_d = count_q + CNT_W'(1);
            end
          end
        end else if (any_mark) begin
          state_d = ST_MOVE;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_MOVE: begin
        ctrl.op = lkvc_pkg::CELL_MOVE;
        if (chain[0].mark) begin
          state_d = (req_q.operation == lkvc_pkg::OP_GET) ? ST_RESP : ST_IDLE;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (rsp_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hit_q       <= 1'b0;
      count_q     <= '0;
      capacity_q  <= lkvc_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_req_i;
    end
    if (rsp_load) begin
      out_rsp_q.hit        <= hit_q;
      out_rsp_q.read_value <= hit_q ? chain[0].value : lkvc_pkg::MISS_VALUE;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_pkg::cell_t prev_w;
    lkvc_pkg::cell_t next_w;

    if (i == 0) begin : g_head
      assign prev_w = '0;
    end else begin : g_body
      assign prev_w = chain[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = chain[i+1];
    end

    lkvc_cell #(
      .CELL_IDX (i),
      .SLOT_W   (CNT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .slot_i (slot),
      .prev_i (prev_w),
      .next_i (next_w),
      .cell_o (chain[i])
    );

    assign mark_vec[i]  = chain[i].mark;
    assign valid_vec[i] = chain[i].valid;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef NO_ASSERTIONS
  a_mark_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(mark_vec))
    else $error("more than one cell marked");

  a_move_has_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE) |-> $onehot(mark_vec))
    else $error("move without a marked cell");

  a_count_matches_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("entry count out of step with valid cells");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("entry count above chain length");

  a_resp_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |=> out_valid_q && (state_q == ST_IDLE))
    else $error("response load did not complete");
`endif

endmodule

`default_nettype wire

FILE: hdl/lkvc_cell.sv
// One entry of the recency-ordered chain: key, value, valid and a mark bit.
// Swaps with its neighbor to carry the marked entry toward the front.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_cell #(
  parameter int CELL_IDX = 0,
  parameter int SLOT_W   = 5
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  lkvc_pkg::cell_ctrl_t     ctrl_i,
  input  wire  [SLOT_W-1:0]        slot_i,
  input  lkvc_pkg::cell_t          prev_i,
  input  lkvc_pkg::cell_t          next_i,
  output lkvc_pkg::cell_t          cell_o
);

  logic            valid_q, valid_d;
  logic            mark_q, mark_d;
  lkvc_pkg::key_t   key_q, key_d;
  lkvc_pkg::value_t value_q, value_d;

  always_comb begin
    valid_d = valid_q;
    mark_d  = mark_q;
    key_d   = key_q;
    value_d = value_q;
    case (ctrl_i.op)
      lkvc_pkg::CELL_MATCH: begin
        mark_d = valid_q && (key_q == ctrl_i.key);
      end
      lkvc_pkg::CELL_UPDATE: begin
        if (mark_q) begin
          value_d = ctrl_i.value;
        end
      end
      lkvc_pkg::CELL_INSERT: begin
        if (slot_i == SLOT_W'(CELL_IDX)) begin
          valid_d = 1'b1;
          mark_d  = 1'b1;
          key_d   = ctrl_i.key;
          value_d = ctrl_i.value;
        end
      end
      lkvc_pkg::CELL_MOVE: begin
        // marked entry moves up one place, the displaced one moves down
        if (next_i.mark) begin
          valid_d = next_i.valid;
          mark_d  = 1'b1;
          key_d   = next_i.key;
          value_d = next_i.value;
        end else if (mark_q && (CELL_IDX != 0)) begin
          valid_d = prev_i.valid;
          mark_d  = 1'b0;
          key_d   = prev_i.key;
          value_d = prev_i.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mark_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      mark_q  <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign cell_o = '{valid: valid_q, mark: mark_q, key: key_q, value: value_q};

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache_core: queue-fed request driver,
// result monitor and an in-line LRU cache predictor. Depends on lkvc_pkg and the core RTL.

module tb;
  import lkvc_pkg::*;

  localparam int NSLOT = DEF_ENTRIES;

  typedef struct {
    req_t        req;
    int unsigned gap;
  } stim_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  req_t               in_req_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rsp_t               out_rsp_o;
  logic               cfg_we_i = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata_i = '0;

  lru_key_value_cache_core #(.ENTRIES(NSLOT)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow cache state
  key_t             slot_key [NSLOT];
  value_t           slot_val [NSLOT];
  bit               slot_used [NSLOT];
  int unsigned      slot_age [NSLOT];
  int unsigned      used_cnt = 0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  stim_t       pending_q [$];
  rsp_t        get_rsp_q [$];
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          gap_armed = 1'b0;
  int unsigned gap_left = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned rx_wait = 0;
  int unsigned rx_hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned err_cnt = 0;
  int unsigned n_get = 0, n_hit = 0, n_put = 0, n_evict = 0, n_cfg = 0;

  initial begin
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  end

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // most recent gets age 0, newer entries age by one
  function automatic void promote(input int s);
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_used[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic bit lru_apply(input req_t r, output rsp_t rsp);
    int found;
    int victim;
    int free_slot;
    int unsigned lim;
    found = -1;
    victim = -1;
    free_slot = -1;
    rsp = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == r.key) found = i;
    end
    if (r.operation == OP_GET) begin
      n_get++;
      if (found >= 0) begin
        n_hit++;
        rsp.hit = 1'b1;
        rsp.read_value = slot_val[found];
        promote(found);
      end else begin
        rsp.hit = 1'b0;
        rsp.read_value = MISS_VALUE;
      end
      return 1'b1;
    end
    n_put++;
    if (found >= 0) begin
      slot_val[found] = r.write_value;
      promote(found);
      return 1'b0;
    end
    lim = (cap_reg == 0) ? 1 : (cap_reg > NSLOT) ? NSLOT : cap_reg;
    if (used_cnt >= lim) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      end
      if (victim >= 0) begin
        slot_used[victim] = 1'b0;
        used_cnt--;
        n_evict++;
      end
    end
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_slot = i;
    end
    if (free_slot >= 0) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_used[i]) slot_age[i]++;
      end
      slot_key[free_slot] = r.key;
      slot_val[free_slot] = r.write_value;
      slot_used[free_slot] = 1'b1;
      slot_age[free_slot] = 0;
      used_cnt++;
    end
    return 1'b0;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    stim_t s;
    logic  nxt_valid;
    req_t  nxt_req;
    nxt_valid = in_valid_i;
    nxt_req = in_req_i;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      nxt_valid = 1'b0;
      if (!gap_armed && pending_q.size() > 0) begin
        gap_left = pending_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_armed) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          s = pending_q.pop_front();
          nxt_valid = 1'b1;
          nxt_req = s.req;
          gap_armed = 1'b0;
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_req_i <= nxt_req;
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rx_hold_req > 0) begin
      hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (out_taken) rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
      if (cfg_we_i) begin
        cap_reg = cfg_wdata_i;
        n_cfg++;
      end
      if (in_valid_i && !in_stall_o) begin
        if (lru_apply(in_req_i, exp_rsp)) get_rsp_q.push_back(exp_rsp);
      end
      if (out_valid_o && !out_stall_i) begin
        if (get_rsp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result hit=%b read_value=%h",
                     $realtime, out_rsp_o.hit, out_rsp_o.read_value);
        end else begin
          exp_rsp = get_rsp_q.pop_front();
          if (out_rsp_o.hit !== exp_rsp.hit || out_rsp_o.read_value !== exp_rsp.read_value) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch hit exp=%b act=%b read_value exp=%h act=%h",
                       $realtime, exp_rsp.hit, out_rsp_o.hit,
                       exp_rsp.read_value, out_rsp_o.read_value);
          end
        end
      end
    end
  end

  task automatic queue_req(input op_e op, input key_t k, input value_t v);
    stim_t s;
    s.req = '{operation: op, key: k, write_value: v};
    s.gap = tx_idle ? $urandom_range(0, 12) : 0;
    pending_q.push_back(s);
  endtask

  // all requests taken and all results back, then cover the put latency
  task automatic wait_drained();
    while (pending_q.size() != 0 || gap_armed || in_valid_i || get_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (NSLOT + 12) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned pool_sz);
    key_t pool [$];
    key_t k;
    op_e  op;
    for (int i = 0; i < pool_sz; i++) pool.push_back(key_t'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) k = pool[$urandom_range(0, pool_sz - 1)];
      else k = key_t'($urandom);
      op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
      queue_req(op, k, value_t'($urandom));
    end
  endtask

  initial begin
    logic [CAP_W-1:0] c;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes at reset capacity
    queue_req(OP_GET, 32'sd0, 32'sd5);
    queue_req(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_req(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(OP_GET, 32'h8000_0000, 32'h0);
    queue_req(OP_GET, 32'h7fff_ffff, 32'h0);
    queue_req(OP_GET, 32'hffff_ffff, 32'h0);
    queue_req(OP_GET, 32'h0000_0000, 32'h0);
    queue_req(OP_PUT, 32'h8000_0000, 32'h1234_5678);
    queue_req(OP_GET, 32'h8000_0000, 32'h0);
    queue_req(OP_GET, 32'h5555_5555, 32'h0);
    queue_req(OP_PUT, 32'haaaa_aaaa, 32'h5555_5555);
    queue_req(OP_GET, 32'haaaa_aaaa, 32'h0);

    set_capacity(5'd1);
    queue_req(OP_PUT, 32'h0000_0011, 32'h0000_00a1);
    queue_req(OP_PUT, 32'h0000_0022, 32'h0000_00b2);
    queue_req(OP_GET, 32'h0000_0011, 32'h0);
    queue_req(OP_GET, 32'h0000_0022, 32'h0);
    run_random(150, 3);

    set_capacity(5'd0);
    run_random(150, 3);

    set_capacity(5'd31);
    run_random(200, 22);

    // shrink below the current fill
    set_capacity(5'd4);
    run_random(150, 8);

    // long receiver hold with back-to-back requests
    set_capacity(5'd16);
    wait_drained();
    tx_idle = 1'b0;
    rx_hold_req = 300;
    run_random(60, 12);
    wait_drained();
    tx_idle = 1'b1;

    set_capacity(5'd17);
    rx_idle = 1'b0;
    tx_idle = 1'b0;
    run_random(200, 20);
    rx_idle = 1'b1;
    tx_idle = 1'b1;

    for (int p = 0; p < 3; p++) begin
      c = $urandom_range(1, 31);
      set_capacity(c);
      run_random(150, ((c > NSLOT) ? NSLOT : c) + $urandom_range(1, 8));
    end

    set_capacity(5'd16);
    run_random(110, 20);
    wait_drained();
    run_random(110, 20);

    wait_drained();
    $display("Ran %0d gets (%0d hits) and %0d puts (%0d evictions)", n_get, n_hit, n_put,
             n_evict);
    $display("over %0d capacity settings, with random and long output stalls", n_cfg + 1);
    if (err_cnt == 0 && get_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lkvc_pkg.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache_core.sv
verif/tb.sv
